// File: rtl/i2c_master_bit_engine_unit_macros.svh
// Assertion macros shared by the bit engine checker.
// Needs nothing; each macro expands to one labelled concurrent assertion.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2cbe_pkg.sv
// Package for the I2C master bit engine: phase type, command codes, constants.
// No dependencies.
package i2cbe_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WRITE,
        PH_READ,
        PH_RACK,
        PH_WAIT
    } phase_t;

    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_STOP     = 3'd1;
    localparam logic [2:0] KIND_WRITE    = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_WAIT_ACK = 3'd4;

    localparam int unsigned TIMEOUT_W = 7;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 7'd100;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// File: rtl/i2cbe_intf.sv
// Channel interfaces of the I2C master bit engine: tick/command in, line levels out.
// No dependencies.
interface i2cbe_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, kind, write_data, send_ack, sda_in,
                    input ready);
    modport sink   (input valid, cmd_valid, kind, write_data, send_ack, sda_in,
                    output ready);
endinterface

interface i2cbe_line_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_missing, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_missing, output ready);
endinterface

// File: rtl/i2c_master_bit_engine_unit.sv
// I2C master bit engine, top level.
// Depends on i2cbe_pkg and the channel interfaces in i2cbe_intf.sv.
//
// Usage:
//  - tick (sink): one transfer per bus timing tick. It carries the sampled SDA
//    level and, optionally, a command (start, stop, write byte, read byte,
//    wait-for-ACK). A command is taken only when the engine is idle; others
//    are dropped. Codes above wait-for-ACK are ignored.
//  - line (source): one transfer per tick with the SCL/SDA levels, busy,
//    done, the last read byte and the sticky ack-missing flag.
//  - cfg_we/cfg_wdata: writes ack_timeout (reset 100). Write only while idle.
// Latency: the result of a tick is presented on the cycle after its transfer.
// Throughput: one tick per cycle; the line register is the only stage, and a
// new tick is taken in the same cycle the held result is taken.
// Stall: while line is valid and not ready, tick.ready drops and all state
// holds, so the result stays put.
// Reset: lines released (SCL/SDA high), idle, flags and read byte cleared,
// no result pending.
module i2c_master_bit_engine_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cbe_pkg::TIMEOUT_W-1:0]  cfg_wdata,
    i2cbe_tick_if.sink                       cmd_chan,
    i2cbe_line_if.source                     res_chan
);
    import i2cbe_pkg::*;

    // Engine state
    phase_t                 phase_reg,   phase_next;
    logic [1:0]             step_reg,    step_next;
    logic [3:0]             bits_reg,    bits_next;
    logic [7:0]             shift_reg,   shift_next;
    logic [TIMEOUT_W-1:0]   poll_reg,    poll_next;
    logic                   scl_reg,     scl_next;
    logic                   sda_reg,     sda_next;
    logic                   ack_sel_reg, ack_sel_next;
    logic [7:0]             rbyte_reg,   rbyte_next;
    logic                   miss_reg,    miss_next;
    logic                   done_reg,    done_next;
    logic                   valid_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    logic                   tick_fire;
    logic                   cmd_take;
    logic [TIMEOUT_W:0]     poll_inc;

    // Output register frees as soon as it is taken
    assign cmd_chan.ready = !valid_reg || res_chan.ready;
    assign tick_fire      = cmd_chan.valid && cmd_chan.ready;
    assign cmd_take       = (phase_reg == PH_IDLE) && cmd_chan.cmd_valid
                            && (cmd_chan.kind <= KIND_WAIT_ACK);
    assign poll_inc       = {1'b0, poll_reg} + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_sel_next = ack_sel_reg;
        rbyte_next   = rbyte_reg;
        miss_next    = miss_reg;
        done_next    = 1'b0;

        // Command launch: first line change happens on the same tick
        if (cmd_take)
        begin
            miss_next = 1'b0;
            step_next = 2'd0;
            bits_next = 4'd0;
            poll_next = '0;
            unique case (cmd_chan.kind)
                KIND_START: phase_next = PH_START;
                KIND_STOP:  phase_next = PH_STOP;
                KIND_WRITE:
                begin
                    phase_next = PH_WRITE;
                    shift_next = cmd_chan.write_data;
                end
                KIND_READ:
                begin
                    phase_next   = PH_READ;
                    shift_next   = 8'd0;
                    ack_sel_next = cmd_chan.send_ack;
                end
                default:    phase_next = PH_WAIT;
            endcase
        end

        unique case (phase_next)
            PH_START:
            begin
                case (step_next)
                    2'd0:    begin sda_next = 1'b1; step_next = 2'd1; end
                    2'd1:    begin scl_next = 1'b1; step_next = 2'd2; end
                    2'd2:    begin sda_next = 1'b0; step_next = 2'd3; end
                    default:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        step_next  = 2'd0;
                        done_next  = 1'b1;
                    end
                endcase
            end
            PH_STOP:
            begin
                case (step_next)
                    2'd0:
                    begin
                        scl_next  = 1'b0;
                        sda_next  = 1'b0;
                        step_next = 2'd1;
                    end
                    2'd1:    begin scl_next = 1'b1; step_next = 2'd2; end
                    default:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        step_next  = 2'd0;
                        done_next  = 1'b1;
                    end
                endcase
            end
            PH_WRITE:
            begin
                case (step_next)
                    2'd0:
                    begin
                        scl_next  = 1'b0;
                        sda_next  = shift_next[7];
                        step_next = 2'd1;
                    end
                    2'd1:    begin scl_next = 1'b1; step_next = 2'd2; end
                    default:
                    begin
                        scl_next   = 1'b0;
                        shift_next = {shift_next[6:0], 1'b0};
                        bits_next  = bits_next + 4'd1;
                        step_next  = 2'd0;
                        if (bits_next >= BITS_PER_BYTE)
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                endcase
            end
            PH_READ:
            begin
                if (step_next == 2'd0)
                begin
                    // release SDA before the slave drives the bit
                    scl_next  = 1'b0;
                    sda_next  = 1'b1;
                    step_next = 2'd1;
                end
                else
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], cmd_chan.sda_in};
                    bits_next  = bits_next + 4'd1;
                    step_next  = 2'd0;
                    if (bits_next >= BITS_PER_BYTE)
                    begin
                        rbyte_next = shift_next;
                        phase_next = PH_RACK;
                    end
                end
            end
            PH_RACK:
            begin
                case (step_next)
                    2'd0:
                    begin
                        scl_next  = 1'b0;
                        sda_next  = !ack_sel_next;
                        step_next = 2'd1;
                    end
                    2'd1:    begin scl_next = 1'b1; step_next = 2'd2; end
                    default:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        step_next  = 2'd0;
                        done_next  = 1'b1;
                    end
                endcase
            end
            PH_WAIT:
            begin
                case (step_next)
                    2'd0:    begin sda_next = 1'b1; step_next = 2'd1; end
                    2'd1:    begin scl_next = 1'b1; step_next = 2'd2; end
                    default:
                    begin
                        if (!cmd_chan.sda_in)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            step_next  = 2'd0;
                            done_next  = 1'b1;
                        end
                        else if (poll_inc > {1'b0, timeout_reg})
                        begin
                            // timed out: flag it and run the first stop tick now
                            miss_next  = 1'b1;
                            phase_next = PH_STOP;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            step_next  = 2'd1;
                        end
                        else
                        begin
                            poll_next = poll_inc[TIMEOUT_W-1:0];
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            step_reg    <= 2'd0;
            bits_reg    <= 4'd0;
            shift_reg   <= 8'd0;
            poll_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            ack_sel_reg <= 1'b0;
            rbyte_reg   <= 8'd0;
            miss_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (tick_fire)
        begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            bits_reg    <= bits_next;
            shift_reg   <= shift_next;
            poll_reg    <= poll_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            ack_sel_reg <= ack_sel_next;
            rbyte_reg   <= rbyte_next;
            miss_reg    <= miss_next;
            done_reg    <= done_next;
        end
    end

    // Result valid: set by a tick, cleared once taken with no new tick behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_chan.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // State after the tick is the result payload; it holds while stalled
    assign res_chan.valid       = valid_reg;
    assign res_chan.scl_out     = scl_reg;
    assign res_chan.sda_out     = sda_reg;
    assign res_chan.busy_res    = (phase_reg != PH_IDLE);
    assign res_chan.done_res    = done_reg;
    assign res_chan.read_data   = rbyte_reg;
    assign res_chan.ack_missing = miss_reg;

endmodule

// File: rtl/i2cbe_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_unit_macros.svh.
`include "i2c_master_bit_engine_unit_macros.svh"

module i2cbe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_out,
    input logic       sda_out,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_data,
    input logic       ack_missing
);

    // done tick reports the engine as no longer busy
    `CHK_IMPLY(a_done_not_busy, clk, rst_n, out_valid && done_res, !busy_res, "done with busy set")

    // an empty output stage never holds back a tick
    `CHK_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "ready low with no result held")

    // every tick transfer yields a result on the next cycle
    `CHK_NEXT(a_tick_gives_result, clk, rst_n, in_valid && in_ready, out_valid, "tick lost")

    // a stalled result holds its payload
    `CHK_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable({scl_out, sda_out, busy_res, done_res, read_data, ack_missing}), "stalled result changed")

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_i2cbe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd_chan.valid),
    .in_ready    (cmd_chan.ready),
    .out_valid   (res_chan.valid),
    .out_ready   (res_chan.ready),
    .scl_out     (res_chan.scl_out),
    .sda_out     (res_chan.sda_out),
    .busy_res    (res_chan.busy_res),
    .done_res    (res_chan.done_res),
    .read_data   (res_chan.read_data),
    .ack_missing (res_chan.ack_missing)
);

// File: test/i2c_master_bit_engine_unit_tb.sv
// Self-checking bench for i2c_master_bit_engine_unit: a directed tick table, then random command
// sequences, with every line transfer checked against a tick-level model of the engine kept here.
// Depends on i2cbe_pkg, the channel interfaces in i2cbe_intf.sv and the engine RTL.
module i2c_master_bit_engine_unit_tb;
    import i2cbe_pkg::*;

    // One tick as offered on the command channel.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] kind;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // One line transfer as returned by the engine.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rd;
        logic       ack_missing;
    } line_t;

    // Directed row: either an ack_timeout write or a tick repeated reps times.
    // Where pinned is set the expected line is the one typed in the row.
    typedef struct packed {
        logic       cfg;
        logic [6:0] cfg_val;
        logic [7:0] reps;
        tick_t      tk;
        logic       pinned;
        line_t      want;
    } plan_row_t;

    // Command codes the engine must drop
    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    localparam int HOLD_CYCLES = 60;    // long receiver hold-off
    localparam int PHASE_TICKS = 90;    // random ticks per ack_timeout setting
    localparam int DRAIN_LIMIT = 5000;  // cycles allowed for the last results

    // Lines we can read straight off the sequences
    localparam line_t IDLE_LINE  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam line_t START_DONE = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0};
    localparam line_t WAIT_DONE  = '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0};
    localparam line_t TIMED_OUT  = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1};
    localparam line_t NO_LINE    = '0;

    // Directed part, run with ack_timeout at its reset value until the zero write.
    localparam plan_row_t PLAN [25] = '{
        // idle tick straight after reset, then the two unknown kinds
        '{1'b0, 7'd0, 8'd1,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b1, IDLE_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_BAD_LO,   8'h00, 1'b0, 1'b1}, 1'b1, IDLE_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_BAD_HI,   8'hFF, 1'b1, 1'b1}, 1'b1, IDLE_LINE},
        // start, with a stop offered while busy that must be dropped
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_START,    8'h5A, 1'b1, 1'b0}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd2,  '{1'b1, KIND_STOP,     8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b1, START_DONE},
        // write both extreme bytes, SDA input must be ignored
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_WRITE,    8'hFF, 1'b0, 1'b0}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd23, '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_WRITE,    8'h00, 1'b1, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd23, '{1'b0, KIND_BAD_HI,   8'hFF, 1'b1, 1'b1}, 1'b0, NO_LINE},
        // read all ones with ACK, then all zeros with NACK
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_READ,     8'h00, 1'b1, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd18, '{1'b0, KIND_START,    8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_READ,     8'hFF, 1'b0, 1'b0}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd18, '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b0, NO_LINE},
        // wait-ack: one failed poll, then ACK
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_WAIT_ACK, 8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd2,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b1, WAIT_DONE},
        // plain stop
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_STOP,     8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd2,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        // zero timeout: first failed poll gives up, flag stays set through the stop
        '{1'b1, 7'd0, 8'd0,  '0,                                        1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b1, KIND_WAIT_ACK, 8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b1}, 1'b0, NO_LINE},
        '{1'b0, 7'd0, 8'd1,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b1}, 1'b1, TIMED_OUT},
        '{1'b0, 7'd0, 8'd2,  '{1'b0, KIND_START,    8'h00, 1'b0, 1'b0}, 1'b0, NO_LINE},
        // largest timeout before the random part
        '{1'b1, 7'd127, 8'd0, '0,                                       1'b0, NO_LINE}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;

    i2cbe_tick_if tick_bus ();
    i2cbe_line_if line_bus ();

    i2c_master_bit_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_chan  (tick_bus),
        .res_chan  (line_bus)
    );

    // ------------------------------------------------------------------
    // Engine model state, advanced once per accepted tick transfer
    // ------------------------------------------------------------------
    phase_t     eng_phase;
    logic [1:0] eng_step;
    logic [3:0] bits_done;
    logic [7:0] shift_byte;
    logic [6:0] failed_polls;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       ack_pick;     // 1: ACK after read
    logic       ack_lost;     // sticky until next accepted command
    logic       cmd_done;
    logic [7:0] last_read;
    logic [6:0] ack_limit;

    line_t line_q [$];        // lines still owed by the engine, oldest first

    // Stimulus shaping and bookkeeping
    int read_mode;            // 0 all low, 1 all high, 2 random sample levels
    int ack_after;            // failed polls before the slave pulls SDA low
    bit no_idle;              // stretch where neither side idles
    bit hold_req;             // asks the receiver for its long hold-off
    bit prev_lost;
    int errors;
    int checked;
    int ticks_sent;
    int work_ticks;
    int timeouts_seen;
    int cmds_taken [5];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void end_command();
        eng_phase = PH_IDLE;
        eng_step  = 2'd0;
        cmd_done  = 1'b1;
    endfunction

    // SCL low with SDA low, SCL high, SDA high
    function automatic void stop_seq();
        if (eng_step == 2'd0)
        begin
            scl_lvl  = 1'b0;
            sda_lvl  = 1'b0;
            eng_step = 2'd1;
        end
        else if (eng_step == 2'd1)
        begin
            scl_lvl  = 1'b1;
            eng_step = 2'd2;
        end
        else
        begin
            sda_lvl = 1'b1;
            end_command();
        end
    endfunction

    // Advance the model by one tick and return the line it should produce.
    function automatic line_t engine_tick(input tick_t t);
        logic [7:0] tries;
        cmd_done = 1'b0;
        if (eng_phase == PH_IDLE && t.cmd_valid && t.kind <= KIND_WAIT_ACK)
        begin
            ack_lost     = 1'b0;
            eng_step     = 2'd0;
            bits_done    = 4'd0;
            failed_polls = 7'd0;
            case (t.kind)
                KIND_START: eng_phase = PH_START;
                KIND_STOP:  eng_phase = PH_STOP;
                KIND_WRITE:
                begin
                    eng_phase  = PH_WRITE;
                    shift_byte = t.write_data;
                end
                KIND_READ:
                begin
                    eng_phase  = PH_READ;
                    shift_byte = 8'h00;
                    ack_pick   = t.send_ack;
                end
                default:    eng_phase = PH_WAIT;
            endcase
        end

        case (eng_phase)
            PH_START:
            begin
                if (eng_step == 2'd0)
                begin
                    sda_lvl  = 1'b1;
                    eng_step = 2'd1;
                end
                else if (eng_step == 2'd1)
                begin
                    scl_lvl  = 1'b1;
                    eng_step = 2'd2;
                end
                else if (eng_step == 2'd2)
                begin
                    sda_lvl  = 1'b0;
                    eng_step = 2'd3;
                end
                else
                begin
                    scl_lvl = 1'b0;
                    end_command();
                end
            end
            PH_STOP: stop_seq();
            PH_WRITE:
            begin
                if (eng_step == 2'd0)
                begin
                    scl_lvl  = 1'b0;
                    sda_lvl  = shift_byte[7];
                    eng_step = 2'd1;
                end
                else if (eng_step == 2'd1)
                begin
                    scl_lvl  = 1'b1;
                    eng_step = 2'd2;
                end
                else
                begin
                    scl_lvl    = 1'b0;
                    shift_byte = {shift_byte[6:0], 1'b0};
                    bits_done  = bits_done + 4'd1;
                    eng_step   = 2'd0;
                    if (bits_done >= BITS_PER_BYTE)
                        end_command();
                end
            end
            PH_READ:
            begin
                if (eng_step == 2'd0)
                begin
                    scl_lvl  = 1'b0;
                    sda_lvl  = 1'b1;
                    eng_step = 2'd1;
                end
                else
                begin
                    scl_lvl    = 1'b1;
                    shift_byte = {shift_byte[6:0], t.sda_in};
                    bits_done  = bits_done + 4'd1;
                    eng_step   = 2'd0;
                    if (bits_done >= BITS_PER_BYTE)
                    begin
                        last_read = shift_byte;
                        eng_phase = PH_RACK;
                    end
                end
            end
            PH_RACK:
            begin
                if (eng_step == 2'd0)
                begin
                    scl_lvl  = 1'b0;
                    sda_lvl  = ~ack_pick;
                    eng_step = 2'd1;
                end
                else if (eng_step == 2'd1)
                begin
                    scl_lvl  = 1'b1;
                    eng_step = 2'd2;
                end
                else
                begin
                    scl_lvl = 1'b0;
                    end_command();
                end
            end
            PH_WAIT:
            begin
                if (eng_step == 2'd0)
                begin
                    sda_lvl  = 1'b1;
                    eng_step = 2'd1;
                end
                else if (eng_step == 2'd1)
                begin
                    scl_lvl  = 1'b1;
                    eng_step = 2'd2;
                end
                else if (!t.sda_in)
                begin
                    scl_lvl = 1'b0;
                    end_command();
                end
                else
                begin
                    // give up once the failed polls exceed the limit; stop starts now
                    tries = {1'b0, failed_polls} + 8'd1;
                    if (tries > {1'b0, ack_limit})
                    begin
                        ack_lost  = 1'b1;
                        eng_phase = PH_STOP;
                        eng_step  = 2'd0;
                        stop_seq();
                    end
                    else
                        failed_polls = tries[6:0];
                end
            end
            default: ;
        endcase

        return '{scl_lvl, sda_lvl, eng_phase != PH_IDLE, cmd_done, last_read, ack_lost};
    endfunction

    // Next random tick, shaped from the model state: mostly well-formed commands,
    // sensible SDA on sample and poll ticks, noise everywhere else.
    function automatic tick_t next_tick();
        tick_t       t;
        int unsigned pick;
        t.cmd_valid  = ($urandom_range(3) == 0);
        t.kind       = 3'($urandom_range(7));
        t.write_data = 8'($urandom);
        t.send_ack   = 1'($urandom);
        t.sda_in     = 1'($urandom);
        if (eng_phase == PH_IDLE)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                t.cmd_valid = 1'b0;
            else if (pick < 14)
            begin
                t.cmd_valid = 1'b1;
                t.kind      = 3'($urandom_range(KIND_BAD_HI, KIND_BAD_LO));
            end
            else
            begin
                t.cmd_valid = 1'b1;
                pick        = $urandom_range(9);
                if (pick == 0)
                    t.kind = KIND_START;
                else if (pick == 1)
                    t.kind = KIND_STOP;
                else if (pick < 4)
                    t.kind = KIND_WRITE;
                else if (pick < 7)
                    t.kind = KIND_READ;
                else
                    t.kind = KIND_WAIT_ACK;
                pick = $urandom_range(3);
                if (pick == 0)
                    t.write_data = 8'h00;
                else if (pick == 1)
                    t.write_data = 8'hFF;
                read_mode = $urandom_range(2);
                // small limits: ACK just before, at or past the limit;
                // large ones: now and then a slave that never answers
                if (ack_limit <= 7'd8)
                    ack_after = $urandom_range(int'(ack_limit) + 2);
                else if ($urandom_range(5) == 0)
                    ack_after = 200;
                else
                    ack_after = $urandom_range(5);
            end
        end
        else if (eng_phase == PH_READ && eng_step == 2'd1)
        begin
            if (read_mode == 0)
                t.sda_in = 1'b0;
            else if (read_mode == 1)
                t.sda_in = 1'b1;
        end
        else if (eng_phase == PH_WAIT && eng_step == 2'd2)
            t.sda_in = (int'(failed_polls) != ack_after);
        return t;
    endfunction

    // Offer one tick until it is taken, then book what the engine owes for it.
    task automatic put_tick(input tick_t t, input logic pinned, input line_t pinned_line);
        line_t predicted;
        tick_bus.valid      <= 1'b1;
        tick_bus.cmd_valid  <= t.cmd_valid;
        tick_bus.kind       <= t.kind;
        tick_bus.write_data <= t.write_data;
        tick_bus.send_ack   <= t.send_ack;
        tick_bus.sda_in     <= t.sda_in;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        if (eng_phase == PH_IDLE && t.cmd_valid && t.kind <= KIND_WAIT_ACK)
            cmds_taken[t.kind]++;
        predicted = engine_tick(t);
        line_q.push_back(pinned ? pinned_line : predicted);
        ticks_sent++;
        if (predicted.busy || predicted.done)
            work_ticks++;
        if (predicted.ack_missing && !prev_lost)
            timeouts_seen++;
        prev_lost = predicted.ack_missing;
    endtask

    // Sender gap: outside the quiet stretch, idles with a chance of 35 in a hundred, and keeps idling on the same odds.
    task automatic sender_idle();
        int n;
        n = 0;
        while (!no_idle && $urandom_range(99) < 35)
            n++;
        if (n > 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drain every owed line, then write ack_timeout with the engine idle.
    task automatic program_timeout(input logic [6:0] value);
        tick_bus.valid <= 1'b0;
        while (line_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ack_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off on request, and
    // the check of every line transfer against the oldest owed line.
    // ------------------------------------------------------------------
    initial
    begin : line_sink
        int    hold_left;
        bit    hold_served;
        line_t got;
        line_t want;
        hold_left      = 0;
        hold_served    = 1'b0;
        line_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (line_bus.valid && line_bus.ready)
            begin
                got = '{line_bus.scl_out, line_bus.sda_out, line_bus.busy_res,
                        line_bus.done_res, line_bus.read_data, line_bus.ack_missing};
                checked++;
                if (line_q.size() == 0)
                    report($sformatf("line transfer with nothing owed: %p", got));
                else
                begin
                    want = line_q.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda
                        || got.busy !== want.busy || got.done !== want.done
                        || got.rd !== want.rd || got.ack_missing !== want.ack_missing)
                        report($sformatf({"line %0d: expected scl %b sda %b busy %b done %b",
                                          " rd %h ackmiss %b, got scl %b sda %b busy %b",
                                          " done %b rd %h ackmiss %b"}, checked,
                                         want.scl, want.sda, want.busy, want.done,
                                         want.rd, want.ack_missing, got.scl, got.sda,
                                         got.busy, got.done, got.rd, got.ack_missing));
                end
            end
            if (hold_left > 0)
                hold_left--;
            else if (hold_req && !hold_served)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            line_bus.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 35);
        end
    end

    // ------------------------------------------------------------------
    // Sender: reset, directed table, then random phases over several
    // ack_timeout settings, then drain and verdict.
    // ------------------------------------------------------------------
    initial
    begin : tick_source
        int         random_ticks;
        int         phase_ticks;
        int         waited;
        logic [6:0] limits [6];

        eng_phase    = PH_IDLE;
        eng_step     = 2'd0;
        bits_done    = 4'd0;
        shift_byte   = 8'h00;
        failed_polls = 7'd0;
        scl_lvl      = 1'b1;
        sda_lvl      = 1'b1;
        ack_pick     = 1'b0;
        ack_lost     = 1'b0;
        cmd_done     = 1'b0;
        last_read    = 8'h00;
        ack_limit    = ACK_TIMEOUT_RST;
        read_mode    = 0;
        ack_after    = 0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        prev_lost    = 1'b0;
        random_ticks = 0;
        clk          = 1'b0;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        tick_bus.valid      <= 1'b0;
        tick_bus.cmd_valid  <= 1'b0;
        tick_bus.kind       <= KIND_START;
        tick_bus.write_data <= 8'h00;
        tick_bus.send_ack   <= 1'b0;
        tick_bus.sda_in     <= 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < $size(PLAN); r++)
        begin
            if (PLAN[r].cfg)
                program_timeout(PLAN[r].cfg_val);
            else
                for (int k = 0; k < int'(PLAN[r].reps); k++)
                begin
                    put_tick(PLAN[r].tk, PLAN[r].pinned, PLAN[r].want);
                    sender_idle();
                end
        end

        // extremes plus a few middling limits; reset value last
        limits = '{7'd127, 7'd3, 7'd0, 7'($urandom_range(20, 4)), 7'd1, ACK_TIMEOUT_RST};
        foreach (limits[p])
        begin
            program_timeout(limits[p]);
            phase_ticks = 0;
            // each phase ends on a command boundary so the next write finds it idle
            while (phase_ticks < PHASE_TICKS || eng_phase != PH_IDLE)
            begin
                put_tick(next_tick(), 1'b0, NO_LINE);
                phase_ticks++;
                random_ticks++;
                // quiet stretch on both sides, with the receiver hold-off inside it
                // so the sender keeps offering while the engine fills and stalls
                if (random_ticks == 300)
                    no_idle = 1'b1;
                if (random_ticks == 330)
                    hold_req = 1'b1;
                if (random_ticks == 440)
                    no_idle = 1'b0;
                sender_idle();
            end
        end

        tick_bus.valid <= 1'b0;
        waited = 0;
        while (line_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (line_q.size() != 0)
            report($sformatf("%0d owed line transfers never arrived", line_q.size()));

        $display({"Covered %0d ticks (%0d with a command running): start %0d, stop %0d,",
                  " write %0d, read %0d, wait-ack %0d"},
                 ticks_sent, work_ticks, cmds_taken[KIND_START], cmds_taken[KIND_STOP],
                 cmds_taken[KIND_WRITE], cmds_taken[KIND_READ], cmds_taken[KIND_WAIT_ACK]);
        $display("ACK timeouts hit %0d, line transfers checked %0d, errors %0d",
                 timeouts_seen, checked, errors);
        if (errors == 0)
            $display("i2c_master_bit_engine_unit_tb OK");
        else
            $display("i2c_master_bit_engine_unit_tb NOT OK");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("i2c_master_bit_engine_unit_tb NOT OK");
        $finish;
    end

endmodule
